>>> sv/ippt_pkg.sv
package ippt_pkg;

	// queue between the classifier and the parser
	localparam int IPPT_QUEUE_DEPTH = 4;

	// byte codes of interest
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// token kinds
	localparam logic [1:0] TOK_DIGIT = 2'd0;
	localparam logic [1:0] TOK_DOT   = 2'd1;
	localparam logic [1:0] TOK_SLASH = 2'd2;
	localparam logic [1:0] TOK_OTHER = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SEPARATOR = 3'd1;
	localparam logic [2:0] ST_NONDIGIT  = 3'd2;
	localparam logic [2:0] ST_FIELDS    = 3'd3;
	localparam logic [2:0] ST_VALUE     = 3'd4;
	localparam logic [2:0] ST_PREFIX    = 3'd5;

	// address classes
	localparam logic [2:0] CLS_A = 3'd0;
	localparam logic [2:0] CLS_B = 3'd1;
	localparam logic [2:0] CLS_C = 3'd2;
	localparam logic [2:0] CLS_D = 3'd3;
	localparam logic [2:0] CLS_E = 3'd4;

	// address kinds
	localparam logic [1:0] KIND_PRIVATE      = 2'd0;
	localparam logic [1:0] KIND_PUBLIC       = 2'd1;
	localparam logic [1:0] KIND_MULTICAST    = 2'd2;
	localparam logic [1:0] KIND_EXPERIMENTAL = 2'd3;

	localparam int OUT_BITS  = 109;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	// one classified input byte
	typedef struct packed {
		logic       eot;
		logic [1:0] kind;
		logic [3:0] digit;
	} tok_t;

endpackage

>>> sv/ippt_front.sv
module ippt_front import ippt_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // char_code
	input  logic       s_tlast,   // end_of_text
	input  logic       q_full,
	output logic       q_push,
	output tok_t       q_tok
);

	logic [7:0] code;

	assign code     = s_tdata;
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_tok.eot   = s_tlast;
		q_tok.digit = code[3:0];
		if (code inside {[CHAR_ZERO:CHAR_NINE]}) begin
			q_tok.kind = TOK_DIGIT;
		end else if (code == CHAR_DOT) begin
			q_tok.kind = TOK_DOT;
		end else if (code == CHAR_SLASH) begin
			q_tok.kind = TOK_SLASH;
		end else begin
			q_tok.kind = TOK_OTHER;
		end
	end

endmodule

>>> sv/ippt_queue.sv
module ippt_queue import ippt_pkg::*; #(
	parameter int DEPTH = IPPT_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic valid,
	output tok_t head_tok
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tok_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign head_tok = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

>>> sv/ippt_back.sv
module ippt_back import ippt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  tok_t                   q_tok,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_BYTES*8-1:0] m_tdata
);

	// parse state
	logic [2:0]  dot_count_q;
	logic [1:0]  slash_count_q;
	logic        order_bad_q;
	logic        nondigit_q;
	logic [2:0]  field_count_q;
	logic        field_open_q;
	logic [8:0]  accum_q;
	logic        range_bad_q;
	logic [7:0]  octet_q [4];

	// end-of-text snapshot
	logic        valid_s1;
	logic [7:0]  octet_s1 [4];
	logic [8:0]  prefix_s1;
	logic        sep_err_s1;
	logic        nondigit_s1;
	logic        fields_bad_s1;
	logic        range_bad_s1;

	logic        m_tvalid_q;
	logic [OUT_BYTES*8-1:0] m_tdata_q;

	logic        advance;
	logic        load_out;
	logic        take;
	logic        is_digit;
	logic        is_sep;
	logic        is_end;
	logic [11:0] acc_base;
	logic [11:0] acc_mul;
	logic [8:0]  acc_next;
	logic        oct_wr;
	logic [1:0]  oct_idx;
	logic [7:0]  oct_snap [4];

	assign advance  = !m_tvalid_q || m_tready;
	assign load_out = valid_s1 && advance;
	assign q_pop    = q_valid && (!q_tok.eot || !valid_s1 || advance);
	assign take     = q_pop;
	assign is_end   = q_tok.eot;
	assign is_digit = !is_end && (q_tok.kind == TOK_DIGIT);
	assign is_sep   = !is_end && ((q_tok.kind == TOK_DOT) || (q_tok.kind == TOK_SLASH));

	// decimal accumulate with saturation at 256
	always_comb begin
		acc_base = field_open_q ? {3'b000, accum_q} : 12'd0;
		acc_mul  = (acc_base << 3) + (acc_base << 1) + {8'h00, q_tok.digit};
		acc_next = (acc_mul > 12'd256) ? 9'd256 : acc_mul[8:0];
	end

	// closing a field stores its low byte among the first four fields
	always_comb begin
		oct_wr  = field_open_q && (field_count_q >= 3'd1) && (field_count_q <= 3'd4);
		oct_idx = 2'(field_count_q - 3'd1);
		for (int i = 0; i < 4; i++) begin
			oct_snap[i] = (oct_wr && (oct_idx == 2'(i))) ? accum_q[7:0] : octet_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_count_q   <= '0;
			slash_count_q <= '0;
			order_bad_q   <= 1'b0;
			nondigit_q    <= 1'b0;
			field_count_q <= '0;
			field_open_q  <= 1'b0;
			accum_q       <= '0;
			range_bad_q   <= 1'b0;
			valid_s1      <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (take) begin
				if (is_end) begin
					dot_count_q   <= '0;
					slash_count_q <= '0;
					order_bad_q   <= 1'b0;
					nondigit_q    <= 1'b0;
					field_count_q <= '0;
					field_open_q  <= 1'b0;
					accum_q       <= '0;
					range_bad_q   <= 1'b0;
				end else if (is_digit) begin
					if (!field_open_q && (field_count_q < 3'd6)) begin
						field_count_q <= field_count_q + 1'b1;
					end
					field_open_q <= 1'b1;
					accum_q      <= acc_next;
				end else if (is_sep) begin
					if (field_open_q && accum_q[8]) begin
						range_bad_q <= 1'b1;
					end
					field_open_q <= 1'b0;
					accum_q      <= '0;
					if (q_tok.kind == TOK_DOT) begin
						if (dot_count_q < 3'd4) begin
							dot_count_q <= dot_count_q + 1'b1;
						end
					end else begin
						if (dot_count_q < 3'd3) begin
							order_bad_q <= 1'b1;
						end
						if (slash_count_q < 2'd2) begin
							slash_count_q <= slash_count_q + 1'b1;
						end
					end
				end else begin
					nondigit_q <= 1'b1;
				end
			end
			if (take && is_end) begin
				valid_s1 <= 1'b1;
			end else if (load_out) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (is_sep || is_end) && oct_wr) begin
			octet_q[oct_idx] <= accum_q[7:0];
		end
		if (take && is_end) begin
			for (int i = 0; i < 4; i++) begin
				octet_s1[i] <= oct_snap[i];
			end
			prefix_s1     <= field_open_q ? accum_q : 9'd0;
			sep_err_s1    <= (dot_count_q != 3'd3) || (slash_count_q != 2'd1) || order_bad_q;
			nondigit_s1   <= nondigit_q;
			fields_bad_s1 <= (field_count_q != 3'd5);
			range_bad_s1  <= range_bad_q || (field_open_q && accum_q[8]);
		end
	end

	// final checks, address assembly, class and masks
	logic [2:0]  status;
	logic [31:0] addr;
	logic [31:0] mask;
	logic [2:0]  cls;
	logic [1:0]  kind;
	logic        ok;
	logic [7:0]  o0;
	logic [7:0]  o1;

	always_comb begin
		o0   = octet_s1[0];
		o1   = octet_s1[1];
		addr = {octet_s1[0], octet_s1[1], octet_s1[2], octet_s1[3]};
		mask = ~(32'hFFFF_FFFF >> prefix_s1[4:0]);
		if (sep_err_s1) begin
			status = ST_SEPARATOR;
		end else if (nondigit_s1) begin
			status = ST_NONDIGIT;
		end else if (fields_bad_s1) begin
			status = ST_FIELDS;
		end else if (range_bad_s1) begin
			status = ST_VALUE;
		end else if ((prefix_s1 == 9'd0) || (prefix_s1 > 9'd31)) begin
			status = ST_PREFIX;
		end else begin
			status = ST_OK;
		end
		ok = (status == ST_OK);
		if (o0 <= 8'd127) begin
			cls  = CLS_A;
			kind = (o0 == 8'd10) ? KIND_PRIVATE : KIND_PUBLIC;
		end else if ((o0 == 8'd172) && (o1 >= 8'd16) && (o1 <= 8'd31)) begin
			cls  = CLS_B;
			kind = KIND_PRIVATE;
		end else if (o0 <= 8'd191) begin
			cls  = CLS_B;
			kind = KIND_PUBLIC;
		end else if ((o0 == 8'd192) && (o1 == 8'd168)) begin
			cls  = CLS_C;
			kind = KIND_PRIVATE;
		end else if (o0 <= 8'd223) begin
			cls  = CLS_C;
			kind = KIND_PUBLIC;
		end else if (o0 <= 8'd239) begin
			cls  = CLS_D;
			kind = KIND_MULTICAST;
		end else begin
			cls  = CLS_E;
			kind = KIND_EXPERIMENTAL;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (ok) begin
				m_tdata_q <= {3'b000, addr & ~mask, addr & mask, kind, cls,
					prefix_s1[4:0], addr, status};
			end else begin
				m_tdata_q <= {{(OUT_BYTES*8-3){1'b0}}, status};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> sv/ipv4_prefix_text_parser.sv
// path: an end-of-text result goes through the queue, the snapshot and the output register
// to m_tdata and waits in the snapshot while the output is stalled; throughput: one character
// per cycle while the queue has room, results back to back; the classifier and the parser
// are coupled through a small token queue, the output register frees as it is taken
// reset: arst_n clears the queue, parse counters and valid flags; octet and data regs unreset
module ipv4_prefix_text_parser import ippt_pkg::*; #(
	parameter int QUEUE_DEPTH = IPPT_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// character stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // char_code[7:0]
	input  logic                   s_tlast,   // end_of_text
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status[2:0], address[34:3], prefix_len[39:35], address_class[42:40],
	// address_kind[44:43], network_part[76:45], host_part[108:77], zero pad
	output logic [OUT_BYTES*8-1:0] m_tdata
);

	// classified tokens between front and back
	logic q_full;
	logic q_push;
	tok_t q_in_tok;
	logic q_pop;
	logic q_valid;
	tok_t q_head_tok;

	// front: byte classification, accepts while the queue has room
	ippt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tok    (q_in_tok)
	);

	// decoupling queue
	ippt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (q_in_tok),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_tok (q_head_tok)
	);

	// back: parse state, end-of-text snapshot and result register
	ippt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_tok    (q_head_tok),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ippt_pkg::*;

	// random part length, watchdog, the long output stall and the final drain
	localparam int RAND_ITEMS     = 760;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;

	// one result, first field in the lowest bits as on m_tdata
	typedef struct packed {
		logic [31:0] host;
		logic [31:0] net;
		logic [1:0]  kind;
		logic [2:0]  cls;
		logic [4:0]  prefix;
		logic [31:0] addr;
		logic [2:0]  status;
	} parse_result_t;

	// sender and receiver idle rates per phase, in percent
	localparam int TX_IDLE [3] = '{28, 75, 0};
	localparam int RX_IDLE [3] = '{75, 28, 0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // char_code[7:0]
	logic                   s_tlast;   // end_of_text
	logic                   m_tvalid;
	logic                   m_tready;
	// status, address, prefix_len, address_class, address_kind, network_part,
	// host_part, zero pad
	logic [OUT_BYTES*8-1:0] m_tdata;

	ipv4_prefix_text_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// results still owed by the block, oldest first
	parse_result_t pending_results[$];
	int            fail_count = 0;
	int            phase = 0;
	int            items_sent = 0;
	int            stall_cycles = 0;

	// bytes of the text about to be sent
	logic [7:0] text_buf[$];

	// directed table: text, whether the result is typed in, and that result
	string         row_text[$];
	bit            row_typed[$];
	parse_result_t row_result[$];

	// parser state as the block should hold it
	logic [2:0] tally_dots = '0;
	logic [1:0] tally_slashes = '0;
	logic       slash_early = 1'b0;
	logic       junk_seen = 1'b0;
	logic [2:0] tally_fields = '0;
	logic       in_field = 1'b0;
	logic [8:0] field_value = '0;
	logic       value_over = 1'b0;
	logic [7:0] octets [4] = '{default: 8'd0};

	// ------------------------------------------------------------------
	// parser prediction
	// ------------------------------------------------------------------

	// end the current field: range check and octet capture
	function automatic void close_field();
		if (in_field) begin
			if (field_value > 9'd255)
				value_over = 1'b1;
			if (tally_fields >= 3'd1 && tally_fields <= 3'd4)
				octets[tally_fields - 3'd1] = field_value[7:0];
			in_field = 1'b0;
			field_value = '0;
		end
	endfunction

	// one accepted byte; returns 1 and the result on the end-of-text transfer
	function automatic bit parse_char(input logic [7:0] c, input logic eot,
			output parse_result_t r);
		int          v;
		int          prefix;
		logic [31:0] mask;
		r = '0;
		if (!eot) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				if (!in_field) begin
					in_field = 1'b1;
					field_value = '0;
					if (tally_fields < 3'd6)
						tally_fields++;
				end
				v = field_value * 10 + (c - CHAR_ZERO);
				field_value = (v > 256) ? 9'd256 : v[8:0];
			end else if (c == CHAR_DOT) begin
				close_field();
				if (tally_dots < 3'd4)
					tally_dots++;
			end else if (c == CHAR_SLASH) begin
				close_field();
				// slash ahead of the third dot is a separator error
				if (tally_dots < 3'd3)
					slash_early = 1'b1;
				if (tally_slashes < 2'd2)
					tally_slashes++;
			end else begin
				junk_seen = 1'b1;
			end
			return 1'b0;
		end

		// terminator: the open field, if any, is the prefix
		prefix = in_field ? int'(field_value) : 0;
		close_field();

		if (tally_dots != 3'd3 || tally_slashes != 2'd1 || slash_early)
			r.status = ST_SEPARATOR;
		else if (junk_seen)
			r.status = ST_NONDIGIT;
		else if (tally_fields != 3'd5)
			r.status = ST_FIELDS;
		else if (value_over)
			r.status = ST_VALUE;
		else if (prefix < 1 || prefix > 31)
			r.status = ST_PREFIX;
		else
			r.status = ST_OK;

		if (r.status == ST_OK) begin
			r.addr = {octets[0], octets[1], octets[2], octets[3]};
			r.prefix = prefix[4:0];
			mask = 32'hFFFF_FFFF << (32 - prefix);
			r.net = r.addr & mask;
			r.host = r.addr & ~mask;
			// class and kind from the first two octets
			if (octets[0] <= 8'd127) begin
				r.cls = CLS_A;
				r.kind = (octets[0] == 8'd10) ? KIND_PRIVATE : KIND_PUBLIC;
			end else if (octets[0] == 8'd172 && octets[1] >= 8'd16 && octets[1] <= 8'd31) begin
				r.cls = CLS_B;
				r.kind = KIND_PRIVATE;
			end else if (octets[0] <= 8'd191) begin
				r.cls = CLS_B;
				r.kind = KIND_PUBLIC;
			end else if (octets[0] == 8'd192 && octets[1] == 8'd168) begin
				r.cls = CLS_C;
				r.kind = KIND_PRIVATE;
			end else if (octets[0] <= 8'd223) begin
				r.cls = CLS_C;
				r.kind = KIND_PUBLIC;
			end else if (octets[0] <= 8'd239) begin
				r.cls = CLS_D;
				r.kind = KIND_MULTICAST;
			end else begin
				r.cls = CLS_E;
				r.kind = KIND_EXPERIMENTAL;
			end
		end

		// parse state clears for the next text, the octets stay
		tally_dots = '0;
		tally_slashes = '0;
		slash_early = 1'b0;
		junk_seen = 1'b0;
		tally_fields = '0;
		in_field = 1'b0;
		field_value = '0;
		value_over = 1'b0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// text building
	// ------------------------------------------------------------------

	function automatic parse_result_t err_result(input logic [2:0] st);
		parse_result_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	function automatic void add_row(input string text, input bit typed,
			input parse_result_t r);
		row_text.push_back(text);
		row_typed.push_back(typed);
		row_result.push_back(r);
	endfunction

	// '~' stands for a zero byte, which a string cannot hold
	function automatic void load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back((s[i] == "~") ? 8'h00 : s[i]);
	endfunction

	// decimal field, now and then with leading zeros
	function automatic string num_text(input int v);
		if ($urandom_range(9) == 0)
			return $sformatf("%03d", v);
		return $sformatf("%0d", v);
	endfunction

	function automatic int rand_octet();
		if ($urandom_range(19) == 0)
			return $urandom_range(256, 1200);
		return $urandom_range(0, 255);
	endfunction

	// a.b.c.d/n with the first two octets biased toward class boundaries
	function automatic void gen_well_formed();
		int    first_picks [12] = '{0, 10, 127, 128, 172, 191, 192, 223, 224, 239, 240, 255};
		int    second_picks [6] = '{15, 16, 31, 32, 168, 169};
		int    a;
		int    b;
		int    n;
		int    sel;
		a = $urandom_range(1) ? first_picks[$urandom_range(11)] : rand_octet();
		b = $urandom_range(1) ? second_picks[$urandom_range(5)] : rand_octet();
		sel = $urandom_range(19);
		if (sel == 0)
			n = 0;
		else if (sel == 1)
			n = 32;
		else if (sel == 2)
			n = $urandom_range(33, 2000);
		else
			n = $urandom_range(1, 31);
		load_text($sformatf("%s.%s.%s.%s/%s", num_text(a), num_text(b),
			num_text(rand_octet()), num_text(rand_octet()), num_text(n)));
	endfunction

	// separators, digits and arbitrary bytes in any order
	function automatic void gen_noise();
		string alphabet = "0123456789./";
		int    len;
		len = $urandom_range(0, 12);
		text_buf.delete();
		for (int i = 0; i < len; i++)
			text_buf.push_back($urandom_range(1) ? 8'($urandom_range(0, 255))
				: alphabet[$urandom_range(11)]);
	endfunction

	// one edit on a well-formed text: drop, insert or replace a byte
	function automatic void mutate_text();
		int         pos;
		logic [7:0] c;
		pos = $urandom_range(0, text_buf.size() - 1);
		case ($urandom_range(3))
			0: c = CHAR_DOT;
			1: c = CHAR_SLASH;
			2: c = 8'(CHAR_ZERO + $urandom_range(9));
			default: c = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(2))
			0: text_buf.delete(pos);
			1: text_buf.insert(pos, c);
			default: text_buf[pos] = c;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// character side
	// ------------------------------------------------------------------

	// offer one byte, with random idle cycles ahead of it, until transferred
	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < TX_IDLE[phase]) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eot;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	// whole text plus terminator; a typed result overrides the prediction
	task automatic send_text(input bit typed, input parse_result_t typed_result);
		parse_result_t r;
		for (int i = 0; i < text_buf.size(); i++)
			void'(parse_char(text_buf[i], 1'b0, r));
		// the terminator byte carries random content, it is ignored
		for (int i = 0; i <= text_buf.size(); i++) begin
			if (i < text_buf.size())
				send_byte(text_buf[i], 1'b0);
			else
				send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		void'(parse_char(8'h00, 1'b1, r));
		pending_results.push_back(typed ? typed_result : r);
	endtask

	// stop offering until every owed result has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	initial begin
		int rand_start;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed texts: extremes, every class and kind, every error
		add_row("0.0.0.0/1", 1'b1, '{host: 32'h0, net: 32'h0, kind: KIND_PUBLIC, cls: CLS_A,
			prefix: 5'd1, addr: 32'h0, status: ST_OK});
		add_row("255.255.255.255/31", 1'b1, '{host: 32'h1, net: 32'hFFFF_FFFE,
			kind: KIND_EXPERIMENTAL, cls: CLS_E, prefix: 5'd31, addr: 32'hFFFF_FFFF,
			status: ST_OK});
		add_row("10.0.0.1/8", 1'b0, '0);
		add_row("128.0.0.0/2", 1'b0, '0);
		add_row("172.16.5.4/12", 1'b0, '0);
		add_row("172.32.1.1/16", 1'b0, '0);
		add_row("192.168.0.1/24", 1'b0, '0);
		add_row("192.169.0.1/24", 1'b0, '0);
		add_row("224.0.0.5/4", 1'b0, '0);
		add_row("239.255.1.2/30", 1'b0, '0);
		add_row("007.08.0009.1/009", 1'b0, '0);
		add_row("", 1'b1, err_result(ST_SEPARATOR));
		add_row("1.2.3/4", 1'b1, err_result(ST_SEPARATOR));
		add_row("1.2/3.4", 1'b1, err_result(ST_SEPARATOR));
		add_row("1.2.3.4/5/6", 1'b1, err_result(ST_SEPARATOR));
		add_row("1.2.3.4.5/6", 1'b1, err_result(ST_SEPARATOR));
		add_row("1.2.3.4", 1'b1, err_result(ST_SEPARATOR));
		add_row("1.2.3.4x/8", 1'b1, err_result(ST_NONDIGIT));
		add_row("1.2.~3.4/8", 1'b1, err_result(ST_NONDIGIT));
		add_row("1.2.3.4/", 1'b1, err_result(ST_FIELDS));
		add_row("1..3.4/5", 1'b1, err_result(ST_FIELDS));
		add_row("300.2.3.4/8", 1'b1, err_result(ST_VALUE));
		add_row("1.2.3.4/99999", 1'b1, err_result(ST_VALUE));
		add_row("1.2.3.4/0", 1'b1, err_result(ST_PREFIX));
		add_row("1.2.3.4/32", 1'b1, err_result(ST_PREFIX));

		for (int i = 0; i < row_text.size(); i++) begin
			load_text(row_text[i]);
			send_text(row_typed[i], row_result[i]);
		end

		// random texts: mostly well formed, the rest edited or pure noise
		rand_start = items_sent;
		while (items_sent - rand_start < RAND_ITEMS) begin
			if (phase < 2 && items_sent - rand_start >= (phase + 1) * RAND_ITEMS / 3) begin
				wait_drained();
				phase++;
			end
			case ($urandom_range(19))
				0, 1, 2: gen_noise();
				3, 4, 5: begin
					gen_well_formed();
					mutate_text();
				end
				default: gen_well_formed();
			endcase
			send_text(1'b0, '0);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// random back-pressure; one long stall at the start of the last phase
	// fills the token queue so the character side has to stall too
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (phase == 2 && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= RX_IDLE[phase]);
			@(posedge clk);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// every result transfer against the oldest owed result
	always @(posedge clk) begin
		parse_result_t got;
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = parse_result_t'(m_tdata[OUT_BITS-1:0]);
			if (pending_results.size() == 0) begin
				$error("result transfer with none owed, status %0d", got.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("address", want.addr, got.addr);
				check_field("prefix_len", 32'(want.prefix), 32'(got.prefix));
				check_field("address_class", 32'(want.cls), 32'(got.cls));
				check_field("address_kind", 32'(want.kind), 32'(got.kind));
				check_field("network_part", want.net, got.net);
				check_field("host_part", want.host, got.host);
			end
		end
	end

	// watchdog: too long with no transfer on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
